@@ hw/rtl/bfsma_pkg.sv @@
// ----------------------------------------------------------------------------
// bfsma_pkg
// Shared types and constants of the best-fit sequence memory allocator.
// ----------------------------------------------------------------------------
package bfsma_pkg;

   localparam int MEM_WORDS = 2048;
   localparam int MAX_SEQS  = 64;

   localparam int AW = $clog2(MEM_WORDS);
   localparam int SW = AW + 1;
   localparam int EW = AW + 2;
   localparam int IW = $clog2(MAX_SEQS);
   localparam int CW = $clog2(MAX_SEQS + 1);

   localparam int CMD_W  = 2;
   localparam int LEN_W  = 12;
   localparam int ID_W   = 6;
   localparam int OFF_W  = 11;
   localparam int ST_W   = 3;
   localparam int ADDR_W = 12;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [ST_W-1:0] {
      ST_OK           = 3'd0,
      ST_NO_SPACE     = 3'd1,
      ST_NO_ID        = 3'd2,
      ST_NOT_RESERVED = 3'd3,
      ST_NOT_FOUND    = 3'd4
   } status_type;

   typedef struct packed {
      logic [AW-1:0] start;
      logic [SW-1:0] size;
      logic [IW-1:0] owner;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROT,
      CELL_INS,
      CELL_DEL
   } cell_op_type;

   typedef struct packed {
      cell_op_type   op;
      logic [IW-1:0] pos;
      entry_type     fresh;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/bfsma_if.sv @@
// ----------------------------------------------------------------------------
// bfsma_req_if / bfsma_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfsma_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfsma_pkg::CMD_W-1:0]   command;
   logic [bfsma_pkg::LEN_W-1:0]   length;
   logic [bfsma_pkg::ID_W-1:0]    seq_id;
   logic [bfsma_pkg::OFF_W-1:0]   offset;
   modport source (output valid, command, length, seq_id, offset, input ready);
   modport sink   (input valid, command, length, seq_id, offset, output ready);
endinterface

interface bfsma_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfsma_pkg::ST_W-1:0]    status;
   logic [bfsma_pkg::ID_W-1:0]    given_id;
   logic [bfsma_pkg::ADDR_W-1:0]  address;
   modport source (output valid, status, given_id, address, input ready);
   modport sink   (input valid, status, given_id, address, output ready);
endinterface

@@ hw/rtl/bfsma_cell.sv @@
// ----------------------------------------------------------------------------
// bfsma_cell
// One table entry; rotates, opens a slot or closes one with its neighbors.
// ----------------------------------------------------------------------------
module bfsma_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bfsma_pkg::IW-1:0]       index,
   input  bfsma_pkg::cell_ctrl_type       ctrl,
   input  bfsma_pkg::entry_type           left,
   input  bfsma_pkg::entry_type           right,
   output bfsma_pkg::entry_type           entry
);

   bfsma_pkg::entry_type entry_ff, entry_in, reset_value;

   always_comb begin
      reset_value = '0;
      if (index == bfsma_pkg::IW'(1)) begin
         reset_value.start = bfsma_pkg::AW'(bfsma_pkg::MEM_WORDS - 1);
         reset_value.size  = bfsma_pkg::SW'(1);
         reset_value.owner = bfsma_pkg::IW'(1);
      end else if (index == '0) begin
         reset_value.size  = bfsma_pkg::SW'(1);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         bfsma_pkg::CELL_ROT: entry_in = right;
         bfsma_pkg::CELL_INS: begin
            if (index == ctrl.pos) entry_in = ctrl.fresh;
            else if (index > ctrl.pos) entry_in = left;
         end
         bfsma_pkg::CELL_DEL: begin
            if (index >= ctrl.pos) entry_in = right;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff <= reset_value;
      else entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ hw/rtl/best_fit_sequence_memory_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_sequence_memory_allocator
// Sorted sequence table in a chain of cells with best-fit gap search.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   command, length, seq_id, offset
//  rsp      out  valid/ready   status, given_id, address
//
// each request runs a scan while the cell chain rotates once past the head,
// then an apply state, then a response state that waits to be taken
// one request at a time; req.ready is high only while idle, so the next
// request is taken in the cycle after the response at the earliest
// a stalled response holds until taken
// synchronous reset restores the two trap entries and ids 0 and 1
// command 3 is dropped with no response
// ----------------------------------------------------------------------------
module best_fit_sequence_memory_allocator (
   input  logic              clock,
   input  logic              reset,
   bfsma_req_if.sink         req,
   bfsma_rsp_if.source       rsp
);

   localparam int IW = bfsma_pkg::IW;
   localparam int AW = bfsma_pkg::AW;
   localparam int EW = bfsma_pkg::EW;
   localparam int N  = bfsma_pkg::MAX_SEQS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_RESP} state_type;

   state_type                         state_ff;
   logic [IW:0]                       step_ff;
   logic [bfsma_pkg::CMD_W-1:0]       cmd_ff;
   logic [bfsma_pkg::LEN_W-1:0]       len_ff;
   logic [bfsma_pkg::ID_W-1:0]        id_ff;
   logic [bfsma_pkg::OFF_W-1:0]       off_ff;
   logic [N-1:0]                      mask_ff;
   logic [bfsma_pkg::CW-1:0]          count_ff;
   logic [EW-1:0]                     addr_ff;
   logic                              found_ff, exact_ff, idfound_ff, posfound_ff;
   logic [AW-1:0]                     best_addr_ff, best_size_ff, pos_start_ff;
   logic [IW-1:0]                     best_pos_ff, free_id_ff, pos_ff;
   logic                              rsp_valid_ff;
   logic [bfsma_pkg::ST_W-1:0]        status_ff;
   logic [bfsma_pkg::ID_W-1:0]        given_ff;
   logic [bfsma_pkg::ADDR_W-1:0]      address_ff;

   bfsma_pkg::entry_type              cells [N];
   bfsma_pkg::cell_ctrl_type          ctrl;
   bfsma_pkg::entry_type              head;
   logic                              in_range;
   logic [EW-1:0]                     start_ext;
   logic [AW-1:0]                     gap;
   logic [bfsma_pkg::LEN_W-1:0]       gap_ext;
   logic                              do_ins, do_del, id_held;

   assign head      = cells[0];
   assign in_range  = step_ff < (IW + 1)'(count_ff);
   assign start_ext = EW'(head.start);
   assign gap       = (start_ext >= addr_ff) ? AW'(start_ext - addr_ff) : '0;
   assign gap_ext   = bfsma_pkg::LEN_W'(gap);
   assign id_held   = mask_ff[id_ff[IW-1:0]];
   assign do_ins    = (cmd_ff == bfsma_pkg::CMD_INSERT) && found_ff && idfound_ff
                      && (count_ff < bfsma_pkg::CW'(N));
   assign do_del    = (cmd_ff == bfsma_pkg::CMD_REMOVE) && id_held && posfound_ff;

   always_comb begin
      ctrl.op          = bfsma_pkg::CELL_HOLD;
      ctrl.pos         = (cmd_ff == bfsma_pkg::CMD_INSERT) ? best_pos_ff : pos_ff;
      ctrl.fresh.start = best_addr_ff;
      ctrl.fresh.size  = bfsma_pkg::SW'(len_ff);
      ctrl.fresh.owner = free_id_ff;
      if (state_ff == S_SCAN) ctrl.op = bfsma_pkg::CELL_ROT;
      else if (state_ff == S_APPLY && do_ins) ctrl.op = bfsma_pkg::CELL_INS;
      else if (state_ff == S_APPLY && do_del) ctrl.op = bfsma_pkg::CELL_DEL;
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      bfsma_pkg::entry_type left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid
         assign left_w = cells[i-1];
      end
      if (i == N - 1) begin : g_last
         assign right_w = (ctrl.op == bfsma_pkg::CELL_ROT) ? cells[0] : '0;
      end else begin : g_body
         assign right_w = cells[i+1];
      end
      bfsma_cell u_cell (
         .clock (clock),
         .reset (reset),
         .index (IW'(i)),
         .ctrl  (ctrl),
         .left  (left_w),
         .right (right_w),
         .entry (cells[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= N'(3);
         count_ff     <= bfsma_pkg::CW'(2);
         step_ff      <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.command != bfsma_pkg::CMD_UNUSED) begin
                  cmd_ff      <= req.command;
                  len_ff      <= req.length;
                  id_ff       <= req.seq_id;
                  off_ff      <= req.offset;
                  step_ff     <= '0;
                  addr_ff     <= '0;
                  found_ff    <= 1'b0;
                  exact_ff    <= 1'b0;
                  idfound_ff  <= 1'b0;
                  posfound_ff <= 1'b0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (in_range && !exact_ff && len_ff != '0) begin
                  if (gap_ext == len_ff) begin
                     best_addr_ff <= AW'(addr_ff);
                     best_size_ff <= gap;
                     best_pos_ff  <= step_ff[IW-1:0];
                     found_ff     <= 1'b1;
                     exact_ff     <= 1'b1;
                  end else if (gap_ext > len_ff && (!found_ff || gap < best_size_ff)) begin
                     best_addr_ff <= AW'(addr_ff);
                     best_size_ff <= gap;
                     best_pos_ff  <= step_ff[IW-1:0];
                     found_ff     <= 1'b1;
                  end
                  addr_ff <= start_ext + EW'(head.size);
               end
               if (!idfound_ff && !mask_ff[step_ff[IW-1:0]]) begin
                  free_id_ff <= step_ff[IW-1:0];
                  idfound_ff <= 1'b1;
               end
               if (in_range && !posfound_ff && head.owner == id_ff[IW-1:0]) begin
                  pos_ff       <= step_ff[IW-1:0];
                  pos_start_ff <= head.start;
                  posfound_ff  <= 1'b1;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == (IW + 1)'(N - 1)) state_ff <= S_APPLY;
            end
            S_APPLY: begin
               given_ff   <= id_ff;
               address_ff <= '0;
               case (cmd_ff)
                  bfsma_pkg::CMD_INSERT: begin
                     if (!found_ff) status_ff <= bfsma_pkg::ST_NO_SPACE;
                     else if (!do_ins) status_ff <= bfsma_pkg::ST_NO_ID;
                     else begin
                        status_ff  <= bfsma_pkg::ST_OK;
                        given_ff   <= bfsma_pkg::ID_W'(free_id_ff);
                        address_ff <= bfsma_pkg::ADDR_W'(best_addr_ff);
                        mask_ff[free_id_ff] <= 1'b1;
                        count_ff   <= count_ff + 1'b1;
                     end
                  end
                  bfsma_pkg::CMD_REMOVE: begin
                     if (!id_held) status_ff <= bfsma_pkg::ST_NOT_RESERVED;
                     else begin
                        mask_ff[id_ff[IW-1:0]] <= 1'b0;
                        if (!posfound_ff) status_ff <= bfsma_pkg::ST_NOT_FOUND;
                        else begin
                           status_ff  <= bfsma_pkg::ST_OK;
                           address_ff <= bfsma_pkg::ADDR_W'(pos_start_ff);
                           count_ff   <= count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (!posfound_ff) status_ff <= bfsma_pkg::ST_NOT_FOUND;
                     else begin
                        status_ff  <= bfsma_pkg::ST_OK;
                        address_ff <= bfsma_pkg::ADDR_W'(pos_start_ff)
                                      + bfsma_pkg::ADDR_W'(off_ff);
                     end
                  end
               endcase
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready    = (state_ff == S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = status_ff;
   assign rsp.given_id = given_ff;
   assign rsp.address  = address_ff;

endmodule

@@ hw/rtl/bfsma_checker.sv @@
// ----------------------------------------------------------------------------
// bfsma_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfsma_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [bfsma_pkg::CMD_W-1:0]   req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bfsma_pkg::ST_W-1:0]    rsp_status,
   input logic [bfsma_pkg::ADDR_W-1:0]  rsp_address
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command != bfsma_pkg::CMD_UNUSED) |=> !req_ready)
      else $error("ready did not drop after request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_address)))
      else $error("stalled response changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= bfsma_pkg::ST_NOT_FOUND)
      else $error("status out of range");

   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bfsma_pkg::ST_OK) |-> rsp_address == '0)
      else $error("address nonzero on error");

endmodule

bind best_fit_sequence_memory_allocator bfsma_checker u_bfsma_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .req_command (req.command),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_status  (rsp.status),
   .rsp_address (rsp.address)
);

@@ bench/tb_bfsma_checker.sv @@
// ----------------------------------------------------------------------------
// tb_bfsma_checker
// Watches the request and response channels of the allocator, keeps its own
// copy of the sequence table and id mask, and compares every response.
// ----------------------------------------------------------------------------
module tb_bfsma_checker (
   input  logic  clock,
   input  logic  reset,
   bfsma_req_if  req,
   bfsma_rsp_if  rsp,
   output int    fail_count,
   output int    pending
);

   typedef struct {
      bfsma_pkg::status_type             status;
      logic [bfsma_pkg::ID_W-1:0]        given_id;
      logic [bfsma_pkg::ADDR_W-1:0]      address;
   } reply_type;

   reply_type  replies_due[$];
   int unsigned tbl_start[bfsma_pkg::MAX_SEQS];
   int unsigned tbl_size[bfsma_pkg::MAX_SEQS];
   int unsigned tbl_owner[bfsma_pkg::MAX_SEQS];
   int unsigned tbl_count;
   logic [63:0] id_mask;

   function automatic int find_seq(int unsigned id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_owner[i] == id) return i;
      return -1;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < bfsma_pkg::MAX_SEQS; i++) begin
         tbl_start[i] = 0; tbl_size[i] = 0; tbl_owner[i] = 0;
      end
      tbl_size[0] = 1;
      tbl_start[1] = bfsma_pkg::MEM_WORDS - 1; tbl_size[1] = 1; tbl_owner[1] = 1;
      tbl_count = 2;
      id_mask = 64'd3;
   endfunction

   function automatic reply_type allocate(int unsigned len, int unsigned rid);
      reply_type r;
      int unsigned at, best_at, best_sz, best_pos, gap, id;
      bit found;
      r.status = bfsma_pkg::ST_NO_SPACE;
      r.given_id = bfsma_pkg::ID_W'(rid);
      r.address = '0;
      at = 0; best_at = 0; best_sz = 0; best_pos = 0; found = 0;
      if (len == 0) return r;
      for (int i = 0; i < tbl_count; i++) begin
         gap = tbl_start[i] >= at ? tbl_start[i] - at : 0;
         if (gap == len) begin
            best_at = at; best_sz = gap; best_pos = i; found = 1;
            break;
         end
         if (gap > len && (!found || gap < best_sz)) begin
            best_at = at; best_sz = gap; best_pos = i; found = 1;
         end
         at = tbl_start[i] + tbl_size[i];
      end
      if (!found) return r;
      if (&id_mask || tbl_count >= bfsma_pkg::MAX_SEQS) begin
         r.status = bfsma_pkg::ST_NO_ID;
         return r;
      end
      for (id = 0; id < bfsma_pkg::MAX_SEQS; id++)
         if (!id_mask[id]) break;
      id_mask[id] = 1'b1;
      for (int i = tbl_count; i > best_pos; i--) begin
         tbl_start[i] = tbl_start[i-1];
         tbl_size[i]  = tbl_size[i-1];
         tbl_owner[i] = tbl_owner[i-1];
      end
      tbl_start[best_pos] = best_at;
      tbl_size[best_pos]  = len;
      tbl_owner[best_pos] = id;
      tbl_count++;
      r.status = bfsma_pkg::ST_OK;
      r.given_id = bfsma_pkg::ID_W'(id);
      r.address = bfsma_pkg::ADDR_W'(best_at);
      return r;
   endfunction

   function automatic reply_type release_seq(int unsigned id);
      reply_type r;
      int pos;
      r.status = bfsma_pkg::ST_NOT_RESERVED;
      r.given_id = bfsma_pkg::ID_W'(id);
      r.address = '0;
      if (!id_mask[id]) return r;
      id_mask[id] = 1'b0;
      pos = find_seq(id);
      if (pos < 0) begin
         r.status = bfsma_pkg::ST_NOT_FOUND;
         return r;
      end
      r.status = bfsma_pkg::ST_OK;
      r.address = bfsma_pkg::ADDR_W'(tbl_start[pos]);
      for (int i = pos; i + 1 < tbl_count; i++) begin
         tbl_start[i] = tbl_start[i+1];
         tbl_size[i]  = tbl_size[i+1];
         tbl_owner[i] = tbl_owner[i+1];
      end
      tbl_count--;
      tbl_start[tbl_count] = 0; tbl_size[tbl_count] = 0; tbl_owner[tbl_count] = 0;
      return r;
   endfunction

   function automatic reply_type locate(int unsigned id, int unsigned off);
      reply_type r;
      int pos;
      pos = find_seq(id);
      r.given_id = bfsma_pkg::ID_W'(id);
      if (pos < 0) begin
         r.status = bfsma_pkg::ST_NOT_FOUND; r.address = '0;
      end else begin
         r.status = bfsma_pkg::ST_OK;
         r.address = bfsma_pkg::ADDR_W'(tbl_start[pos] + off);
      end
      return r;
   endfunction

   initial begin
      fail_count = 0;
      clear_table();
   end

   assign pending = replies_due.size();

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         replies_due.delete();
         clear_table();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected response st=%0d id=%0d addr=%0d", $time,
                        rsp.status, rsp.given_id, rsp.address);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp.status !== want.status || rsp.given_id !== want.given_id ||
                   rsp.address !== want.address) begin
                  $display("%0t: expected st=%0d id=%0d addr=%0d, got st=%0d id=%0d addr=%0d",
                           $time, want.status, want.given_id, want.address,
                           rsp.status, rsp.given_id, rsp.address);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            case (req.command)
               bfsma_pkg::CMD_INSERT:
                  replies_due.push_back(allocate(req.length, req.seq_id));
               bfsma_pkg::CMD_REMOVE:
                  replies_due.push_back(release_seq(req.seq_id));
               bfsma_pkg::CMD_LOOKUP:
                  replies_due.push_back(locate(req.seq_id, req.offset));
               default: ;
            endcase
         end
      end
   end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, remove and lookup requests into the allocator with random
// gaps and response stalls; a checker beside the block predicts each response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycles = 0;
   bit   hold_rsp = 0;

   bfsma_req_if req ();
   bfsma_rsp_if rsp ();

   best_fit_sequence_memory_allocator u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   tb_bfsma_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
   endfunction

   task automatic send(logic [bfsma_pkg::CMD_W-1:0] cmd, logic [bfsma_pkg::LEN_W-1:0] len,
                       logic [bfsma_pkg::ID_W-1:0] id, logic [bfsma_pkg::OFF_W-1:0] off,
                       bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      repeat (g) @(posedge clock);
      req.valid   <= 1'b1;
      req.command <= cmd;
      req.length  <= len;
      req.seq_id  <= id;
      req.offset  <= off;
      do @(posedge clock); while (!req.ready);
      req.valid <= 1'b0;
   endtask

   // waits first so the checker has logged the last request
   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int g;
      rsp.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
         end
         g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
         rsp.ready <= (g == 0);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [bfsma_pkg::CMD_W-1:0] cmd;
      logic [bfsma_pkg::LEN_W-1:0] len;
      int                          r;
      req.valid   = 1'b0;
      req.command = bfsma_pkg::CMD_INSERT;
      req.length  = '0;
      req.seq_id  = '0;
      req.offset  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: boundaries, every command, error paths
      send(bfsma_pkg::CMD_INSERT, 12'd0, 6'd63, 11'd0, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd2048, 6'd0, 11'd0, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd4095, 6'd0, 11'd0, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd2045, 6'd5, 11'd0, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd2046, 6'd5, 11'd0, 0);
      send(bfsma_pkg::CMD_LOOKUP, 12'd0, 6'd2, 11'd2047, 0);
      send(bfsma_pkg::CMD_LOOKUP, 12'd0, 6'd1, 11'd2047, 0);
      send(bfsma_pkg::CMD_LOOKUP, 12'd0, 6'd63, 11'd0, 0);
      send(bfsma_pkg::CMD_REMOVE, 12'd0, 6'd2, 11'd0, 0);
      send(bfsma_pkg::CMD_REMOVE, 12'd0, 6'd2, 11'd0, 0);
      send(bfsma_pkg::CMD_REMOVE, 12'd0, 6'd63, 11'd0, 0);
      send(bfsma_pkg::CMD_UNUSED, 12'hfff, 6'h3f, 11'h7ff, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd100, 6'd0, 11'd0, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd100, 6'd0, 11'd0, 0);
      send(bfsma_pkg::CMD_REMOVE, 12'd0, 6'd2, 11'd0, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd100, 6'd0, 11'd0, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd50, 6'd0, 11'd0, 0);
      send(bfsma_pkg::CMD_REMOVE, 12'd0, 6'd0, 11'd0, 0);
      send(bfsma_pkg::CMD_LOOKUP, 12'd0, 6'd0, 11'd5, 0);
      send(bfsma_pkg::CMD_INSERT, 12'd1, 6'd0, 11'd0, 0);
      // fill every id to reach the no free id case
      repeat (64) send(bfsma_pkg::CMD_INSERT, 12'd1, 6'd0, 11'd0, 0);
      drain();

      // long receiver hold-off while requests keep coming
      hold_rsp = 1;
      for (int i = 0; i < 8; i++)
         send(bfsma_pkg::CMD_LOOKUP, 12'd0, bfsma_pkg::ID_W'($urandom_range(0, 63)),
              bfsma_pkg::OFF_W'($urandom), 0);
      drain();

      for (int i = 0; i < 750; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) cmd = bfsma_pkg::CMD_INSERT;
         else if (r < 70) cmd = bfsma_pkg::CMD_REMOVE;
         else if (r < 98) cmd = bfsma_pkg::CMD_LOOKUP;
         else cmd = bfsma_pkg::CMD_UNUSED;
         r = $urandom_range(0, 19);
         if (r == 0) len = bfsma_pkg::LEN_W'($urandom);
         else if (r < 3) len = bfsma_pkg::LEN_W'($urandom_range(200, 2048));
         else len = bfsma_pkg::LEN_W'($urandom_range(1, 60));
         send(cmd, len, bfsma_pkg::ID_W'($urandom), bfsma_pkg::OFF_W'($urandom), 1);
         if (i == 375) drain();
      end
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ best_fit_sequence_memory_allocator.f @@
hw/rtl/bfsma_pkg.sv
hw/rtl/bfsma_if.sv
hw/rtl/bfsma_cell.sv
hw/rtl/best_fit_sequence_memory_allocator.sv
hw/rtl/bfsma_checker.sv
bench/tb_bfsma_checker.sv
bench/tb_top.sv
